// ===== sv/srba_pkg.sv =====
`timescale 1ns / 1ps

package srba_pkg;

  // Fixed widths of the result value and the configuration registers
  localparam int OUT_W     = 32;
  localparam int CFG_W     = 31;
  localparam int LEN_CFG_W = 13;
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam logic [CFG_W-1:0]     NEAR_RESET = 31'd5033;
  localparam logic [CFG_W-1:0]     FAR_RESET  = 31'd167772;
  localparam logic [LEN_CFG_W-1:0] LEN_RESET  = 13'd181;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PICK_MIDDLE    = 2'd0,
    REG_NEAR_THRESHOLD = 2'd1,
    REG_FAR_THRESHOLD  = 2'd2,
    REG_BLOCK_LENGTH   = 2'd3
  } srba_reg_t;

  // Sequencer to output stage
  typedef struct packed {
    logic push;   // new result for the pending slot
    logic flush;  // item done: release the pending result as the last one
  } srba_oreq_t;

  // Output stage to sequencer
  typedef struct packed {
    logic room;        // a push or flush can be taken this cycle
    logic pend_valid;  // a result is waiting in the pending slot
  } srba_ostat_t;

endpackage

// ===== sv/srba_alu.sv =====
`timescale 1ns / 1ps

module srba_alu #(
  parameter int W = 45
) (
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic                sub,
  output logic signed [W-1:0] y
);

  assign y = sub ? (a - b) : (a + b);

endmodule

// ===== sv/srba_out.sv =====
`timescale 1ns / 1ps

module srba_out import srba_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  srba_oreq_t         oreq,
  input  logic [OUT_W-1:0]   res,
  output srba_ostat_t        ostat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [OUT_W-1:0]   block_value,
  output logic               last_of_run
);

  logic             pend_valid;
  logic [OUT_W-1:0] pend;
  logic             out_free;
  logic             load_out;

  assign out_free         = !out_valid || !out_stall;
  assign ostat.room       = !pend_valid || out_free;
  assign ostat.pend_valid = pend_valid;
  // a push moves an earlier result of the same item on, not yet the last
  assign load_out         = pend_valid && (oreq.push || oreq.flush);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid   <= 1'b1;
        block_value <= pend;
        last_of_run <= oreq.flush;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (oreq.push) begin
        pend       <= res;
        pend_valid <= 1'b1;
      end else if (oreq.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/srba_seq.sv =====
`timescale 1ns / 1ps

module srba_seq import srba_pkg::*; #(
  parameter int MAX_BLOCK   = 4096,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          end_of_stream,
  output logic                          in_stall,
  input  logic                          pick_middle,
  input  logic [CFG_W-1:0]              near_threshold,
  input  logic [CFG_W-1:0]              far_threshold,
  input  logic [LEN_CFG_W-1:0]          block_length,
  input  srba_ostat_t                   ostat,
  output srba_oreq_t                    oreq,
  output logic [OUT_W-1:0]              res
);

  localparam int LW     = $clog2(MAX_BLOCK + 1);
  localparam int CW     = (LW > LEN_CFG_W) ? LW : LEN_CFG_W;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_BLOCK);
  localparam int ALU_W  = (SUM_W + 1 > OUT_W + 1) ? SUM_W + 1 : OUT_W + 1;
  localparam int DW     = SAMPLE_BITS + 1;
  localparam int CNT_W  = $clog2(SUM_W);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_C_FAR, S_C_NEAR_P, S_D_NEXT, S_C_NEAR_N, S_ACC,
    S_CHECK, S_ABS, S_RND, S_DIV, S_SGN, S_EMIT, S_NEXTP, S_FLUSH
  } state_t;

  state_t                         state;
  logic signed [SAMPLE_BITS-1:0]  held;
  logic                           held_valid;
  logic signed [SAMPLE_BITS-1:0]  cur;
  logic                           eos;
  logic                           phase;
  logic signed [SAMPLE_BITS-1:0]  last;
  logic                           first_seen;
  logic [LW-1:0]                  pos;
  logic signed [SUM_W-1:0]        sum;
  logic signed [DW-1:0]           diff;
  logic                           far_hit;
  logic                           near_p;
  logic                           spike;
  logic                           neg;
  logic [SUM_W-1:0]               dvd;
  logic [LW-1:0]                  rem;
  logic [CNT_W-1:0]               cnt;

  logic [CW-1:0]                  blk_ext;
  logic [LW-1:0]                  len;
  logic [LW-1:0]                  len_half;
  logic [LW-1:0]                  pos_inc;
  logic signed [SAMPLE_BITS-1:0]  x_cur;
  logic signed [SAMPLE_BITS-1:0]  v;
  logic signed [ALU_W-1:0]        sum_ext;
  logic [LW:0]                    rem_sh;
  logic                           ge;
  logic signed [ALU_W-1:0]        alu_a;
  logic signed [ALU_W-1:0]        alu_b;
  logic                           alu_sub;
  logic signed [ALU_W-1:0]        alu_y;

  // Block length of zero acts as one; above the maximum it saturates
  assign blk_ext = CW'(block_length);
  always_comb begin
    if (block_length == '0) begin
      len = LW'(1);
    end else if (blk_ext > CW'(MAX_BLOCK)) begin
      len = LW'(MAX_BLOCK);
    end else begin
      len = LW'(blk_ext);
    end
  end

  assign len_half = len >> 1;
  assign pos_inc  = pos + LW'(1);
  assign x_cur    = phase ? cur : held;
  assign v        = spike ? last : x_cur;
  assign sum_ext  = ALU_W'(sum);
  assign rem_sh   = {rem, dvd[SUM_W-1]};
  assign ge       = !alu_y[ALU_W-1];

  assign in_stall   = (state != S_IDLE);
  assign oreq.push  = (state == S_EMIT) && ostat.room;
  assign oreq.flush = (state == S_FLUSH) && ostat.room;

  // Operand selection for the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_START: begin
        alu_a   = ALU_W'(x_cur);
        alu_b   = ALU_W'(last);
        alu_sub = 1'b1;
      end
      S_C_FAR: begin
        // threshold minus |diff|; negative means the jump is larger
        alu_a   = ALU_W'(far_threshold);
        alu_b   = ALU_W'(diff);
        alu_sub = !diff[DW-1];
      end
      S_C_NEAR_P, S_C_NEAR_N: begin
        alu_a   = ALU_W'(near_threshold);
        alu_b   = ALU_W'(diff);
        alu_sub = !diff[DW-1];
      end
      S_D_NEXT: begin
        alu_a   = ALU_W'(x_cur);
        alu_b   = ALU_W'(cur);
        alu_sub = 1'b1;
      end
      S_ACC: begin
        alu_a = sum_ext;
        alu_b = ALU_W'(v);
      end
      S_ABS: begin
        alu_b   = sum_ext;
        alu_sub = sum[SUM_W-1];
      end
      S_RND: begin
        alu_a = ALU_W'(dvd);
        alu_b = ALU_W'(len_half);
      end
      S_DIV: begin
        alu_a   = ALU_W'(rem_sh);
        alu_b   = ALU_W'(len);
        alu_sub = 1'b1;
      end
      S_SGN: begin
        alu_b   = ALU_W'(dvd);
        alu_sub = neg;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  srba_alu #(
    .W (ALU_W)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held       <= '0;
      held_valid <= 1'b0;
      cur        <= '0;
      eos        <= 1'b0;
      phase      <= 1'b0;
      last       <= '0;
      first_seen <= 1'b0;
      pos        <= '0;
      sum        <= '0;
      diff       <= '0;
      far_hit    <= 1'b0;
      near_p     <= 1'b0;
      spike      <= 1'b0;
      neg        <= 1'b0;
      dvd        <= '0;
      rem        <= '0;
      cnt        <= '0;
      res        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur <= sample;
            eos <= end_of_stream;
            if (!first_seen) begin
              last       <= sample;
              first_seen <= 1'b1;
            end
            if (held_valid) begin
              phase <= 1'b0;
              state <= S_START;
            end else if (end_of_stream) begin
              phase <= 1'b1;
              state <= S_START;
            end else begin
              held       <= sample;
              held_valid <= 1'b1;
            end
          end
        end
        S_START: begin
          if (pick_middle) begin
            if (pos == len_half) begin
              sum <= SUM_W'(x_cur);
            end
            spike <= 1'b0;
            last  <= x_cur;
            pos   <= pos_inc;
            state <= S_CHECK;
          end else begin
            diff  <= alu_y[DW-1:0];
            state <= S_C_FAR;
          end
        end
        S_C_FAR: begin
          far_hit <= alu_y[ALU_W-1];
          state   <= S_C_NEAR_P;
        end
        S_C_NEAR_P: begin
          near_p <= alu_y[ALU_W-1];
          state  <= S_D_NEXT;
        end
        S_D_NEXT: begin
          diff  <= alu_y[DW-1:0];
          state <= S_C_NEAR_N;
        end
        S_C_NEAR_N: begin
          spike <= (near_p && alu_y[ALU_W-1]) || far_hit;
          state <= S_ACC;
        end
        S_ACC: begin
          sum   <= alu_y[SUM_W-1:0];
          last  <= v;
          pos   <= pos_inc;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (pos >= len) begin
            pos <= '0;
            if (pick_middle) begin
              res   <= sum_ext[OUT_W-1:0];
              sum   <= '0;
              state <= S_EMIT;
            end else begin
              state <= S_ABS;
            end
          end else begin
            state <= S_NEXTP;
          end
        end
        S_ABS: begin
          neg   <= sum[SUM_W-1];
          dvd   <= alu_y[SUM_W-1:0];
          sum   <= '0;
          state <= S_RND;
        end
        S_RND: begin
          dvd   <= alu_y[SUM_W-1:0];
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle
          rem <= ge ? alu_y[LW-1:0] : rem_sh[LW-1:0];
          dvd <= {dvd[SUM_W-2:0], ge};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(SUM_W - 1)) begin
            state <= S_SGN;
          end
        end
        S_SGN: begin
          res   <= alu_y[OUT_W-1:0];
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (ostat.room) begin
            state <= S_NEXTP;
          end
        end
        S_NEXTP: begin
          if (!phase && eos) begin
            // end of stream: the new sample is its own successor
            phase <= 1'b1;
            state <= S_START;
          end else begin
            if (eos) begin
              held_valid <= 1'b0;
              held       <= '0;
              first_seen <= 1'b0;
              pos        <= '0;
              sum        <= '0;
            end else begin
              held       <= cur;
              held_valid <= 1'b1;
            end
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (ostat.room) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== sv/spike_reject_block_averager.sv =====
`timescale 1ns / 1ps

// Spike-rejecting block averager. Samples pass through a one-item hold stage
// so each can be judged against its successor; one shared adder/subtractor
// under a small sequencer does all the arithmetic and the block takes no new
// item while it works. A sample that only fills the hold stage is just held.
// Processing a held sample in average mode takes the differences, three
// threshold compares, an accumulate and bookkeeping; pick mode only keeps
// the middle sample and the count. A completed average block adds a
// bit-serial restoring divide on the shared adder with SUM_W quotient bits,
// where SUM_W = SAMPLE_BITS + clog2(MAX_BLOCK); a completed pick block adds
// only the emit. An end-of-stream item that follows a held sample runs the
// processing twice. Results leave through a pending slot and an output
// register, so a stalled output holds the sequencer only when both are full.
module spike_reject_block_averager import srba_pkg::*; #(
  parameter int MAX_BLOCK   = 4096,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          end_of_stream,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [OUT_W-1:0]       block_value,
  output logic                          last_of_run,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  logic                 pick_middle;
  logic [CFG_W-1:0]     near_threshold;
  logic [CFG_W-1:0]     far_threshold;
  logic [LEN_CFG_W-1:0] block_length;
  srba_oreq_t           oreq;
  srba_ostat_t          ostat;
  logic [OUT_W-1:0]     res;
  logic [OUT_W-1:0]     out_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      pick_middle    <= 1'b0;
      near_threshold <= NEAR_RESET;
      far_threshold  <= FAR_RESET;
      block_length   <= LEN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PICK_MIDDLE:    pick_middle    <= cfg_data[0];
        REG_NEAR_THRESHOLD: near_threshold <= cfg_data;
        REG_FAR_THRESHOLD:  far_threshold  <= cfg_data;
        REG_BLOCK_LENGTH:   block_length   <= cfg_data[LEN_CFG_W-1:0];
      endcase
    end
  end

  srba_seq #(
    .MAX_BLOCK   (MAX_BLOCK),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .sample         (sample),
    .end_of_stream  (end_of_stream),
    .in_stall       (in_stall),
    .pick_middle    (pick_middle),
    .near_threshold (near_threshold),
    .far_threshold  (far_threshold),
    .block_length   (block_length),
    .ostat          (ostat),
    .oreq           (oreq),
    .res            (res)
  );

  srba_out u_out (
    .clk         (clk),
    .rst         (rst),
    .oreq        (oreq),
    .res         (res),
    .ostat       (ostat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .block_value (out_value),
    .last_of_run (last_of_run)
  );

  assign block_value = out_value;

  // Ready only once every result of the previous item has left the pending slot
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !ostat.pend_valid)
    else $error("ready with a result still pending");

  // An end-of-stream item always runs the processing
  a_eos_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && end_of_stream) |=> in_stall)
    else $error("end of stream item not processed");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (!in_stall && !out_valid))
    else $error("block not idle after reset");

endmodule
